### hw/rtl/olp_pkg.sv
// Shared types and codes of the overlap layer placer.
package olp_pkg;

   // One stored rectangle: centre and size, 8 fraction bits each.
   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic [30:0]        box_width;
      logic [30:0]        box_height;
   } entry_type;

   // Outcome of one overlap probe.
   typedef struct packed {
      logic valid;
      logic hit;
   } hit_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_PLACE,
      ST_RESPOND
   } state_type;

   localparam logic [1:0] STATUS_PLACED   = 2'd0;
   localparam logic [1:0] STATUS_NULL     = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

endpackage

### hw/rtl/olp_overlap_unit.sv
// Shared two-step overlap test of the item against one stored rectangle.
module olp_overlap_unit #(
   parameter int TAG_W = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                probe_valid,
   input  logic [TAG_W-1:0]    probe_row,
   input  olp_pkg::entry_type  stored,
   input  olp_pkg::entry_type  item,
   output olp_pkg::hit_type    result,
   output logic [TAG_W-1:0]    result_row
);

   logic             valid_ff;
   logic [TAG_W-1:0] row_ff;
   logic [32:0]      dx_ff;
   logic [32:0]      dy_ff;
   logic [31:0]      sw_ff;
   logic [31:0]      sh_ff;

   logic [33:0] dx2;
   logic [33:0] dy2;
   logic [33:0] sum_x;
   logic [33:0] sum_y;
   logic        ok_x;
   logic        ok_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= probe_valid;
      end
   end

   // Stage one: centre differences and size sums.
   always_ff @(posedge clock) begin
      row_ff <= probe_row;
      dx_ff  <= {stored.center_x[31], stored.center_x} - {item.center_x[31], item.center_x};
      dy_ff  <= {stored.center_y[31], stored.center_y} - {item.center_y[31], item.center_y};
      sw_ff  <= {1'b0, stored.box_width} + {1'b0, item.box_width};
      sh_ff  <= {1'b0, stored.box_height} + {1'b0, item.box_height};
   end

   // Stage two: 2*|d| < s, negative d tested as 2*d + s > 0.
   always_comb begin
      dx2   = {dx_ff, 1'b0};
      dy2   = {dy_ff, 1'b0};
      sum_x = dx2 + {2'b00, sw_ff};
      sum_y = dy2 + {2'b00, sh_ff};
      if (dx_ff[32]) begin
         ok_x = !sum_x[33] && (sum_x != 34'd0);
      end else begin
         ok_x = dx2 < {2'b00, sw_ff};
      end
      if (dy_ff[32]) begin
         ok_y = !sum_y[33] && (sum_y != 34'd0);
      end else begin
         ok_y = dy2 < {2'b00, sh_ff};
      end
   end

   assign result.valid = valid_ff;
   assign result.hit   = ok_x && ok_y;
   assign result_row   = row_ff;

endmodule

### hw/rtl/overlap_layer_placer.sv
// Top level of the overlap layer placer: sequencer, rectangle store and grid counts.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------------------
//  req     | in        | req_valid/req_stall | present, center_x/y, box_width/height
//  rsp     | out       | rsp_valid/rsp_stall | status, placed_row/column, rows/columns_in_use
//
//  A null shape's result goes to the output register without a scan; a shape's result
//  follows the scan of the stored rectangles, the drain and the placement: the one
//  overlap unit checks one stored rectangle a cycle, fed from the single read port of
//  the store. The next transfer is taken once the result has gone to the output register.
//  Reset empties the grid at once; the store itself is not cleared. req_stall is high
//  while an item is in work; a result waiting under rsp_stall holds the next result.
module overlap_layer_placer #(
   parameter int MAX_ROWS    = 8,
   parameter int MAX_COLUMNS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_present,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic [30:0]        req_box_width,
   input  logic [30:0]        req_box_height,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [2:0]         rsp_placed_row,
   output logic [2:0]         rsp_placed_column,
   output logic [3:0]         rsp_rows_in_use,
   output logic [3:0]         rsp_columns_in_use
);

   localparam int SLOTS     = MAX_ROWS * MAX_COLUMNS;
   localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_W     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int ROWCNT_W  = $clog2(MAX_ROWS + 1);
   localparam int COLCNT_W  = $clog2(MAX_COLUMNS + 1);
   localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // Sequencer.
   olp_pkg::state_type state_ff, state_in;
   olp_pkg::entry_type item_ff, item_in;
   logic [ROW_W-1:0]    scan_row_ff, scan_row_in;
   logic [COL_W-1:0]    scan_col_ff, scan_col_in;
   logic [SLOT_W-1:0]   base_ff, base_in;
   logic                drain_ff, drain_in;
   logic [ROWCNT_W-1:0] target_ff, target_in;

   // Grid bookkeeping: every row fills from column 0 upward, so a fill
   // count per row stands for its occupied flags.
   logic [ROWCNT_W-1:0] row_count_ff, row_count_in;
   logic [COLCNT_W-1:0] col_count_ff, col_count_in;
   logic [COLCNT_W-1:0] fill_ff [MAX_ROWS];
   logic                fill_we;
   logic [ROW_W-1:0]    fill_idx;
   logic [COLCNT_W-1:0] fill_rd;
   logic [COLCNT_W-1:0] fill_wdata;

   // Rectangle store with registered read.
   olp_pkg::entry_type mem [SLOTS];
   logic                mem_we;
   logic [SLOT_W-1:0]   mem_waddr;
   logic [SLOT_W-1:0]   rd_addr;
   olp_pkg::entry_type  rd_data_ff;
   logic                rd_valid_ff;
   logic [ROW_W-1:0]    rd_row_ff;
   logic                issue;

   olp_pkg::hit_type    hit;
   logic [ROW_W-1:0]    hit_row;

   // Pending result and output register.
   logic [1:0]          res_status_ff, res_status_in;
   logic [ROWCNT_W-1:0] res_row_ff, res_row_in;
   logic [COLCNT_W-1:0] res_col_ff, res_col_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [2:0]          rsp_row_ff, rsp_row_in;
   logic [2:0]          rsp_col_ff, rsp_col_in;
   logic [3:0]          rsp_rows_ff, rsp_rows_in;
   logic [3:0]          rsp_cols_ff, rsp_cols_in;

   // Placement decision.
   logic                new_row;
   logic                need_col;
   logic                grid_full;
   logic [COLCNT_W-1:0] place_col;

   assign req_stall = (state_ff != olp_pkg::ST_IDLE);

   assign fill_idx = (state_ff == olp_pkg::ST_PLACE) ? target_ff[ROW_W-1:0] : scan_row_ff;
   assign fill_rd  = fill_ff[fill_idx];
   assign issue    = (state_ff == olp_pkg::ST_SCAN) && (COLCNT_W'(scan_col_ff) < fill_rd);
   assign rd_addr  = SLOT_W'(int'(base_ff) + int'(scan_col_ff));

   always_comb begin
      new_row = (target_ff == row_count_ff);
      if (new_row) begin
         place_col = '0;
         need_col  = (col_count_ff == '0);
      end else begin
         place_col = fill_rd;
         need_col  = (fill_rd == col_count_ff);
      end
      grid_full = (new_row && (int'(row_count_ff) == MAX_ROWS))
               || (need_col && (int'(col_count_ff) == MAX_COLUMNS));
      mem_waddr  = SLOT_W'(int'(target_ff) * MAX_COLUMNS + int'(place_col));
      fill_wdata = place_col + COLCNT_W'(1);
   end

   olp_overlap_unit #(
      .TAG_W (ROW_W)
   ) u_overlap (
      .clock       (clock),
      .reset       (reset),
      .probe_valid (rd_valid_ff),
      .probe_row   (rd_row_ff),
      .stored      (rd_data_ff),
      .item        (item_ff),
      .result      (hit),
      .result_row  (hit_row)
   );

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      scan_row_in   = scan_row_ff;
      scan_col_in   = scan_col_ff;
      base_in       = base_ff;
      drain_in      = drain_ff;
      target_in     = target_ff;
      row_count_in  = row_count_ff;
      col_count_in  = col_count_ff;
      res_status_in = res_status_ff;
      res_row_in    = res_row_ff;
      res_col_in    = res_col_ff;
      fill_we       = 1'b0;
      mem_we        = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_rows_in   = rsp_rows_ff;
      rsp_cols_in   = rsp_cols_ff;

      // Rows come out of the scan in rising order: the last hit sets the target.
      if (hit.valid && hit.hit) begin
         target_in = ROWCNT_W'(int'(hit_row) + 1);
      end

      unique case (state_ff)
         olp_pkg::ST_IDLE: begin
            if (req_valid) begin
               item_in.center_x   = req_center_x;
               item_in.center_y   = req_center_y;
               item_in.box_width  = req_box_width;
               item_in.box_height = req_box_height;
               target_in   = '0;
               scan_row_in = '0;
               scan_col_in = '0;
               base_in     = '0;
               drain_in    = 1'b0;
               if (!req_present) begin
                  res_status_in = olp_pkg::STATUS_NULL;
                  res_row_in    = '0;
                  res_col_in    = '0;
                  state_in      = olp_pkg::ST_RESPOND;
               end else if (row_count_ff == '0) begin
                  state_in = olp_pkg::ST_DRAIN;
               end else begin
                  state_in = olp_pkg::ST_SCAN;
               end
            end
         end
         olp_pkg::ST_SCAN: begin
            // Step through the occupied prefix of each row, one slot a cycle.
            if (COLCNT_W'(int'(scan_col_ff) + 1) < fill_rd) begin
               scan_col_in = COL_W'(int'(scan_col_ff) + 1);
            end else begin
               scan_col_in = '0;
               scan_row_in = ROW_W'(int'(scan_row_ff) + 1);
               base_in     = SLOT_W'(int'(base_ff) + MAX_COLUMNS);
               if (ROWCNT_W'(int'(scan_row_ff) + 1) == row_count_ff) begin
                  state_in = olp_pkg::ST_DRAIN;
               end
            end
         end
         olp_pkg::ST_DRAIN: begin
            // Let the read stage and the overlap unit empty.
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = olp_pkg::ST_PLACE;
            end
         end
         olp_pkg::ST_PLACE: begin
            if (grid_full) begin
               res_status_in = olp_pkg::STATUS_FULL;
               res_row_in    = '0;
               res_col_in    = '0;
            end else begin
               mem_we        = 1'b1;
               fill_we       = 1'b1;
               res_status_in = olp_pkg::STATUS_PLACED;
               res_row_in    = target_ff;
               res_col_in    = place_col;
               if (new_row) begin
                  row_count_in = row_count_ff + ROWCNT_W'(1);
               end
               if (need_col) begin
                  col_count_in = col_count_ff + COLCNT_W'(1);
               end
            end
            state_in = olp_pkg::ST_RESPOND;
         end
         olp_pkg::ST_RESPOND: begin
            // Hold until the output register is free, then hand over.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_row_in    = 3'(res_row_ff);
               rsp_col_in    = 3'(res_col_ff);
               rsp_rows_in   = 4'(row_count_ff);
               rsp_cols_in   = 4'(col_count_ff);
               state_in      = olp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = olp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= olp_pkg::ST_IDLE;
         row_count_ff <= '0;
         col_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
         drain_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= issue;
         drain_ff     <= drain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < MAX_ROWS; r++) begin
            fill_ff[r] <= '0;
         end
      end else if (fill_we) begin
         fill_ff[target_ff[ROW_W-1:0]] <= fill_wdata;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      scan_row_ff   <= scan_row_in;
      scan_col_ff   <= scan_col_in;
      base_ff       <= base_in;
      target_ff     <= target_in;
      res_status_ff <= res_status_in;
      res_row_ff    <= res_row_in;
      res_col_ff    <= res_col_in;
      rsp_status_ff <= rsp_status_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_rows_ff   <= rsp_rows_in;
      rsp_cols_ff   <= rsp_cols_in;
      rd_row_ff     <= scan_row_ff;
   end

   // Rectangle store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= item_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_placed_row     = rsp_row_ff;
   assign rsp_placed_column  = rsp_col_ff;
   assign rsp_rows_in_use    = rsp_rows_ff;
   assign rsp_columns_in_use = rsp_cols_ff;

endmodule

### bench/testbench.sv
// Self-checking testbench for the overlap layer placer: directed and random rectangles.
`timescale 1ns / 100ps

module testbench;

   localparam int GRID_ROWS    = 8;
   localparam int GRID_COLS    = 8;
   localparam int SLOT_COUNT   = GRID_ROWS * GRID_COLS;
   localparam int RANDOM_ITEMS = 1000;
   // The limit allows many times the longest scan of a full grid, plus the
   // longest sender gap and receiver stall.
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 120;

   // One rectangle as it crosses the request channel.
   typedef struct packed {
      logic               present;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic [30:0]        box_width;
      logic [30:0]        box_height;
   } shape_type;

   // One placement outcome as it crosses the response channel.
   typedef struct packed {
      logic [1:0] status;
      logic [2:0] row;
      logic [2:0] column;
      logic [3:0] rows;
      logic [3:0] columns;
   } placement_type;

   typedef enum {STALL_NONE, STALL_SPARSE, STALL_LONG, STALL_HEAVY} stall_mode_type;

   // Layer grid mirror: predicts each placement and checks the responses.
   class placement_board_type;
      olp_pkg::entry_type grid [SLOT_COUNT];
      bit                 taken [SLOT_COUNT];
      int                 rows_used;
      int                 cols_used;
      placement_type      pending_q [$];
      int                 errors;
      int                 transfers;
      int                 placed;
      int                 rejected;
      int                 overflowed;

      function new();
         rows_used = 0;
         cols_used = 0;
         errors = 0;
         transfers = 0;
         placed = 0;
         rejected = 0;
         overflowed = 0;
         foreach (taken[i]) taken[i] = 1'b0;
      endfunction

      function bit overlaps(int slot, shape_type s);
         longint dx, dy, wsum, hsum;
         dx = longint'($signed(grid[slot].center_x)) - longint'($signed(s.center_x));
         dy = longint'($signed(grid[slot].center_y)) - longint'($signed(s.center_y));
         if (dx < 0) dx = -dx;
         if (dy < 0) dy = -dy;
         wsum = longint'({33'b0, grid[slot].box_width}) + longint'({33'b0, s.box_width});
         hsum = longint'({33'b0, grid[slot].box_height}) + longint'({33'b0, s.box_height});
         return (2 * dx < wsum) && (2 * dy < hsum);
      endfunction

      function void note_request(shape_type s);
         placement_type p;
         int            target, col, new_rows, new_cols, slot;
         bit            found;
         p = '0;
         transfers++;
         if (!s.present) begin
            p.status  = olp_pkg::STATUS_NULL;
            p.rows    = 4'(rows_used);
            p.columns = 4'(cols_used);
            rejected++;
            pending_q.push_back(p);
            return;
         end
         target = 0;
         for (int r = 0; r < rows_used; r++)
            for (int c = 0; c < cols_used; c++) begin
               slot = r * GRID_COLS + c;
               if (taken[slot] && overlaps(slot, s)) target = r + 1;
            end
         new_rows = rows_used;
         new_cols = cols_used;
         found = 1'b0;
         col = 0;
         if (target >= rows_used) begin
            new_rows = rows_used + 1;
            if (cols_used > 0) found = 1'b1;
         end else begin
            for (int c = 0; c < cols_used; c++)
               if (!taken[target * GRID_COLS + c]) begin
                  found = 1'b1;
                  col = c;
                  break;
               end
         end
         if (!found) begin
            new_cols = cols_used + 1;
            col = cols_used;
         end
         if (new_rows > GRID_ROWS || new_cols > GRID_COLS) begin
            p.status  = olp_pkg::STATUS_FULL;
            p.rows    = 4'(rows_used);
            p.columns = 4'(cols_used);
            overflowed++;
         end else begin
            slot = target * GRID_COLS + col;
            grid[slot].center_x   = s.center_x;
            grid[slot].center_y   = s.center_y;
            grid[slot].box_width  = s.box_width;
            grid[slot].box_height = s.box_height;
            taken[slot] = 1'b1;
            rows_used = new_rows;
            cols_used = new_cols;
            p.status  = olp_pkg::STATUS_PLACED;
            p.row     = 3'(target);
            p.column  = 3'(col);
            p.rows    = 4'(rows_used);
            p.columns = 4'(cols_used);
            placed++;
         end
         pending_q.push_back(p);
      endfunction

      function void compare_field(string field, int want, int got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            errors++;
         end
      endfunction

      function void check_response(placement_type got);
         placement_type want;
         if (pending_q.size() == 0) begin
            $error("response with nothing expected: status %0d row %0d column %0d",
                   got.status, got.row, got.column);
            errors++;
            return;
         end
         want = pending_q.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("placed_row", want.row, got.row);
         compare_field("placed_column", want.column, got.column);
         compare_field("rows_in_use", want.rows, got.rows);
         compare_field("columns_in_use", want.columns, got.columns);
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_present = 1'b0;
   logic signed [31:0] req_center_x = '0;
   logic signed [31:0] req_center_y = '0;
   logic [30:0]        req_box_width = '0;
   logic [30:0]        req_box_height = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic [2:0]         rsp_placed_row;
   logic [2:0]         rsp_placed_column;
   logic [3:0]         rsp_rows_in_use;
   logic [3:0]         rsp_columns_in_use;

   placement_board_type board;

   overlap_layer_placer #(
      .MAX_ROWS    (GRID_ROWS),
      .MAX_COLUMNS (GRID_COLS)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_present        (req_present),
      .req_center_x       (req_center_x),
      .req_center_y       (req_center_y),
      .req_box_width      (req_box_width),
      .req_box_height     (req_box_height),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_placed_row     (rsp_placed_row),
      .rsp_placed_column  (rsp_placed_column),
      .rsp_rows_in_use    (rsp_rows_in_use),
      .rsp_columns_in_use (rsp_columns_in_use)
   );

   always #10 clock = ~clock;

   // Receiver back-pressure: switch between stall patterns at random intervals,
   // so that stalls hit every phase of the work, with quiet stretches too.
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left = 0;
   int             stall_left = 0;

   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(50, 400);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         STALL_NONE: begin
            rsp_stall <= 1'b0;
         end
         STALL_SPARSE: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         STALL_LONG: begin
            // hold stall for a run of cycles, then release
            if (stall_left > 0) begin
               stall_left--;
               rsp_stall <= 1'b1;
            end else if ($urandom_range(0, 7) == 0) begin
               stall_left = $urandom_range(1, 30);
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
         default: begin
            rsp_stall <= ($urandom_range(0, 1) == 0);
         end
      endcase
   end

   // Monitor: sample both channels at the rising edge, feed the board and
   // run the watchdog on cycles without any transfer.
   shape_type     seen_shape;
   placement_type seen_result;
   int            idle_cycles = 0;
   bit            moved;

   always @(posedge clock) begin
      if (!reset) begin
         moved = 1'b0;
         if (req_valid && !req_stall) begin
            seen_shape = '{req_present, req_center_x, req_center_y,
                           req_box_width, req_box_height};
            board.note_request(seen_shape);
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            seen_result = '{rsp_status, rsp_placed_row, rsp_placed_column,
                            rsp_rows_in_use, rsp_columns_in_use};
            board.check_response(seen_result);
            moved = 1'b1;
         end
         if (moved) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("watchdog: no transfer for %0d cycles, %0d responses outstanding",
                        idle_cycles, board.pending_q.size());
               $display("status: fail");
               $finish;
            end
         end
      end
   end

   function automatic shape_type make_shape(bit present, logic [31:0] cx, logic [31:0] cy,
                                            logic [31:0] w, logic [31:0] h);
      shape_type s;
      s.present    = present;
      s.center_x   = cx;
      s.center_y   = cy;
      s.box_width  = w[30:0];
      s.box_height = h[30:0];
      return s;
   endfunction

   // Random rectangle: half of them clustered shapes that stack into layers, the
   // rest full-range values for bit coverage, tiny boxes and null shapes.
   function automatic shape_type random_shape();
      int          pick;
      logic [31:0] base_x, base_y;
      pick   = $urandom_range(0, 99);
      base_x = $urandom_range(0, 3) * 32'h0100_0000 - 32'h0200_0000;
      base_y = $urandom_range(0, 3) * 32'h0100_0000 - 32'h0200_0000;
      if (pick < 10)
         return make_shape(1'b0, $urandom, $urandom, $urandom, $urandom);
      if (pick < 35)
         return make_shape(1'b1, $urandom, $urandom, $urandom, $urandom);
      if (pick < 85)
         return make_shape(1'b1, base_x + $urandom_range(0, 2047) - 1024,
                           base_y + $urandom_range(0, 2047) - 1024,
                           $urandom_range(0, 4096), $urandom_range(0, 4096));
      return make_shape(1'b1, $urandom, $urandom, $urandom_range(0, 3), $urandom_range(0, 3));
   endfunction

   // Present one rectangle at the falling edge and hold it until it transfers.
   task automatic send_shape(shape_type s);
      req_present    = s.present;
      req_center_x   = s.center_x;
      req_center_y   = s.center_y;
      req_box_width  = s.box_width;
      req_box_height = s.box_height;
      req_valid      = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Drop valid for a gap; a zero gap keeps the burst going.
   task automatic pause_sender(int cycles);
      if (cycles > 0) begin
         req_valid = 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   initial begin
      int sent;
      int burst;
      board = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Null shape on an empty grid.
      send_shape(make_shape(1'b0, $urandom, $urandom, $urandom, $urandom));
      // Zero-size boxes never overlap, even at the same centre.
      send_shape(make_shape(1'b1, 0, 0, 0, 0));
      pause_sender($urandom_range(0, 3));
      send_shape(make_shape(1'b1, 0, 0, 0, 0));
      // Largest box covers the zero boxes and opens row 1.
      send_shape(make_shape(1'b1, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      // Edges that only touch do not overlap; one unit closer does.
      send_shape(make_shape(1'b1, 0, 0, 512, 512));
      send_shape(make_shape(1'b1, 512, 0, 512, 512));
      pause_sender($urandom_range(0, 3));
      send_shape(make_shape(1'b1, 511, 0, 512, 512));
      // Extreme centres with the largest sizes.
      send_shape(make_shape(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_shape(make_shape(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      // Null shape with every field bit set.
      send_shape(make_shape(1'b0, '1, '1, '1, '1));
      // Fill row 0 until a column is needed beyond the limit.
      for (int k = 0; k < 6; k++)
         send_shape(make_shape(1'b1, 32'h7000_0000 + k * 4096, 32'h7000_0000, 0, 0));
      pause_sender($urandom_range(0, 3));
      // Stack identical boxes until a row is needed beyond the limit.
      for (int k = 0; k < 8; k++)
         send_shape(make_shape(1'b1, 1000, 1000, 256, 256));

      // Random bursts with random gaps between them.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 16);
         for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
            send_shape(random_shape());
            sent++;
         end
         if ($urandom_range(0, 4) == 0) pause_sender(0);
         else pause_sender($urandom_range(1, 20));
      end
      req_valid = 1'b0;

      // Wait for every outstanding response, then let the block settle.
      while (board.pending_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d transfers: %0d placed, %0d null rejected, %0d grid full",
               board.transfers, board.placed, board.rejected, board.overflowed);
      $display("grid ended at %0d rows by %0d columns, %0d mismatches",
               board.rows_used, board.cols_used, board.errors);
      if (board.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
